### sv/led_pixel_symbol_packer_unit_assert.svh
// Assertion macros for the packer's checker file.
`ifndef LED_PIXEL_SYMBOL_PACKER_UNIT_ASSERT_SVH
`define LED_PIXEL_SYMBOL_PACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packer check failed");

`endif

### sv/lpsp_pkg.sv
// Types and constants shared by the LED pixel symbol packer.
package lpsp_pkg;

    // Fixed geometry of the line stream.
    localparam int WORD_BITS   = 32;
    localparam int SYMBOL_BITS = 3;
    localparam int DATA_BITS   = 24;
    localparam int COLOR_BITS  = 8;
    localparam int STREAM_BITS = DATA_BITS * SYMBOL_BITS;
    localparam int BUF_BITS    = WORD_BITS - 1 + STREAM_BITS;
    localparam int FILL_W      = $clog2(BUF_BITS + 1);
    localparam int USED_W      = $clog2(WORD_BITS + 1);
    localparam int SHIFT_W     = $clog2(WORD_BITS);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_ZERO = 2'd1;

    // Reset patterns: long high for a one, short high for a zero.
    localparam logic [SYMBOL_BITS-1:0] SYMBOL_HIGH_RST = 3'd6;
    localparam logic [SYMBOL_BITS-1:0] SYMBOL_LOW_RST  = 3'd4;

    // One pixel as held in the input register.
    typedef struct packed {
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] blue;
        logic                  pixel_on;
        logic                  last_pixel;
    } pixel_t;

    // Expanded symbol stream of one pixel, first line bit at the top.
    typedef struct packed {
        logic [STREAM_BITS-1:0] stream;
        logic                   last;
    } sym_item_t;

endpackage

### sv/lpsp_if.sv
// Channel interfaces: pixel input, packed word output and configuration writes.
interface lpsp_pixel_if;
    logic                               valid;
    logic                               ready;
    logic [lpsp_pkg::COLOR_BITS-1:0]    green;
    logic [lpsp_pkg::COLOR_BITS-1:0]    red;
    logic [lpsp_pkg::COLOR_BITS-1:0]    blue;
    logic                               pixel_on;
    logic                               last_pixel;

    modport source (output valid, green, red, blue, pixel_on, last_pixel, input ready);
    modport sink   (input valid, green, red, blue, pixel_on, last_pixel, output ready);
endinterface

interface lpsp_word_if;
    logic                           valid;
    logic                           ready;
    logic [lpsp_pkg::WORD_BITS-1:0] word;
    logic [lpsp_pkg::USED_W-1:0]    bits_used;
    logic                           last_word;

    modport source (output valid, word, bits_used, last_word, input ready);
    modport sink   (input valid, word, bits_used, last_word, output ready);
endinterface

interface lpsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpsp_pkg::CFG_IDX_W-1:0]  index;
    logic [lpsp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/lpsp_expand.sv
// Expands one pixel into its stream of line symbols.
module lpsp_expand (
    input  lpsp_pkg::pixel_t                   pix,
    input  logic [lpsp_pkg::SYMBOL_BITS-1:0]   symbol_one,
    input  logic [lpsp_pkg::SYMBOL_BITS-1:0]   symbol_zero,
    output logic [lpsp_pkg::STREAM_BITS-1:0]   stream
);

    logic [lpsp_pkg::DATA_BITS-1:0] data;

    // A disabled pixel sends all zero bits.
    assign data = pix.pixel_on ? {pix.green, pix.red, pix.blue} : '0;

    // Data bit i owns symbol slot i, so the top data bit lands first on the line.
    always_comb
    begin
        for (int i = 0; i < lpsp_pkg::DATA_BITS; i++)
        begin
            stream[i*lpsp_pkg::SYMBOL_BITS +: lpsp_pkg::SYMBOL_BITS] =
                data[i] ? symbol_one : symbol_zero;
        end
    end

endmodule

### sv/lpsp_packer.sv
// Bit accumulator that cuts the symbol stream into words and flushes at frame end.
module lpsp_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sym_valid,
    input  lpsp_pkg::sym_item_t   sym,
    output logic                  sym_take,
    lpsp_word_if.source           res
);

    localparam logic [lpsp_pkg::FILL_W-1:0] WORD_FILL   =
        lpsp_pkg::FILL_W'(lpsp_pkg::WORD_BITS);
    localparam logic [lpsp_pkg::FILL_W-1:0] STREAM_FILL =
        lpsp_pkg::FILL_W'(lpsp_pkg::STREAM_BITS);

    logic [lpsp_pkg::BUF_BITS-1:0]  acc_reg, acc_next;
    logic [lpsp_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic                           flush_reg, flush_next;
    logic                           out_valid_reg, out_valid_next;
    logic [lpsp_pkg::WORD_BITS-1:0] out_word_reg, out_word_next;
    logic [lpsp_pkg::USED_W-1:0]    out_used_reg, out_used_next;
    logic                           out_last_reg, out_last_next;

    logic                           full;
    logic                           emit;
    logic                           flush_done;
    logic                           load;
    logic [lpsp_pkg::FILL_W-1:0]    after;
    logic [lpsp_pkg::BUF_BITS-1:0]  base;
    logic [lpsp_pkg::BUF_BITS-1:0]  ext;

    // Word emission: a full word, or the partial tail while flushing.
    assign full       = (fill_reg >= WORD_FILL);
    assign emit       = (full || (flush_reg && (fill_reg != '0)))
                        && (!out_valid_reg || res.ready);
    assign flush_done = emit && flush_reg && (fill_reg <= WORD_FILL);

    // Bits left in the accumulator once this cycle's word is gone.
    always_comb
    begin
        if (emit)
        begin
            after = full ? (fill_reg - WORD_FILL) : '0;
            base  = acc_reg << lpsp_pkg::WORD_BITS;
        end
        else
        begin
            after = fill_reg;
            base  = acc_reg;
        end
    end

    // A new pixel joins when fewer than a word of bits remain and no flush stays open past this cycle's word.
    assign load     = sym_valid && (after < WORD_FILL) && (!flush_reg || flush_done);
    assign sym_take = load;

    // Place the new stream directly behind the remaining bits.
    assign ext = {sym.stream, {(lpsp_pkg::BUF_BITS - lpsp_pkg::STREAM_BITS){1'b0}}};

    always_comb
    begin
        acc_next   = load ? (base | (ext >> after[lpsp_pkg::SHIFT_W-1:0])) : base;
        fill_next  = after + (load ? STREAM_FILL : '0);
        if (load)
        begin
            flush_next = sym.last;
        end
        else if (flush_done)
        begin
            flush_next = 1'b0;
        end
        else
        begin
            flush_next = flush_reg;
        end
    end

    // Output register: holds a word until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        out_word_next  = out_word_reg;
        out_used_next  = out_used_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = acc_reg[lpsp_pkg::BUF_BITS-1 -: lpsp_pkg::WORD_BITS];
            out_used_next  = full ? lpsp_pkg::USED_W'(lpsp_pkg::WORD_BITS)
                                  : fill_reg[lpsp_pkg::USED_W-1:0];
            out_last_next  = flush_reg && (fill_reg <= WORD_FILL);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        out_used_reg <= out_used_next;
        out_last_reg <= out_last_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.word      = out_word_reg;
    assign res.bits_used = out_used_reg;
    assign res.last_word = out_last_reg;

endmodule

### sv/led_pixel_symbol_packer_unit.sv
// Top level of the LED pixel symbol packer.
//
// Pixels enter on pix (green, red, blue, pixel_on, last_pixel) and are
// turned into 3-bit line symbols, 72 line bits per pixel, packed from bit
// 31 downward into 32-bit words on res. bits_used is 32 for a full word;
// the word that closes a frame carries last_word and may be partial,
// zero-padded below bits_used. Symbol patterns are written on cfg
// (index 0: pattern for a one, index 1: pattern for a zero); cfg is
// always ready and other indexes are ignored.
// The first word of a pixel passes the input register, the accumulator and
// the output register on its way to res. The single 32-bit result port sets
// the rate: one word leaves per cycle while the receiver is ready, and a
// frame end with a partial tail sends it as one more, shorter word.
// An input register and the output register decouple the two sides: a
// stalled receiver stops the accumulator, and pix is ready while the input
// register is empty or its pixel is being taken. Reset empties the
// accumulator, drops any partial word and restores the patterns to 6 and 4.
module led_pixel_symbol_packer_unit (
    input  logic          clk,
    input  logic          rst_n,
    lpsp_cfg_if.sink      cfg,
    lpsp_pixel_if.sink    pix,
    lpsp_word_if.source   res
);

    logic [lpsp_pkg::SYMBOL_BITS-1:0] sym_one_reg, sym_one_next;
    logic [lpsp_pkg::SYMBOL_BITS-1:0] sym_zero_reg, sym_zero_next;
    logic                             in_valid_reg, in_valid_next;
    lpsp_pkg::pixel_t                 in_pix_reg, in_pix_next;
    logic                             sym_take;
    logic [lpsp_pkg::STREAM_BITS-1:0] sym_stream;
    lpsp_pkg::sym_item_t              sym;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        sym_one_next  = sym_one_reg;
        sym_zero_next = sym_zero_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                lpsp_pkg::REG_SYMBOL_ONE:  sym_one_next  = cfg.data;
                lpsp_pkg::REG_SYMBOL_ZERO: sym_zero_next = cfg.data;
                default:                   ;
            endcase
        end
    end

    // Input register: refills in the same cycle the packer takes its pixel.
    assign pix.ready = !in_valid_reg || sym_take;

    always_comb
    begin
        in_valid_next = in_valid_reg && !sym_take;
        in_pix_next   = in_pix_reg;
        if (pix.valid && pix.ready)
        begin
            in_valid_next = 1'b1;
            in_pix_next   = '{green: pix.green, red: pix.red, blue: pix.blue,
                              pixel_on: pix.pixel_on, last_pixel: pix.last_pixel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_one_reg  <= lpsp_pkg::SYMBOL_HIGH_RST;
            sym_zero_reg <= lpsp_pkg::SYMBOL_LOW_RST;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            sym_one_reg  <= sym_one_next;
            sym_zero_reg <= sym_zero_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_pix_reg <= in_pix_next;
    end

    // Symbol expansion of the held pixel.
    lpsp_expand u_expand (
        .pix         (in_pix_reg),
        .symbol_one  (sym_one_reg),
        .symbol_zero (sym_zero_reg),
        .stream      (sym_stream)
    );

    assign sym = '{stream: sym_stream, last: in_pix_reg.last_pixel};

    // Word packing and frame flush.
    lpsp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (in_valid_reg),
        .sym       (sym),
        .sym_take  (sym_take),
        .res       (res)
    );

endmodule

### sv/lpsp_checker.sv
// Port-level checks on the packer's result channel, bound to the top level.
`include "led_pixel_symbol_packer_unit_assert.svh"

module lpsp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [lpsp_pkg::WORD_BITS-1:0] res_word,
    input logic [lpsp_pkg::USED_W-1:0]    res_bits_used,
    input logic                           res_last_word
);

    // A stalled word stays put.
    `LPSP_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_word) && $stable(res_bits_used) && $stable(res_last_word))

    // The bit count is never empty and never above a word.
    `LPSP_ASSERT_NOW(a_used_range, clk, rst_n, res_valid, (res_bits_used != '0) && (res_bits_used <= lpsp_pkg::USED_W'(lpsp_pkg::WORD_BITS)))

    // Only the word that closes a frame may be partial.
    `LPSP_ASSERT_NOW(a_partial_last, clk, rst_n, res_valid && !res_last_word, res_bits_used == lpsp_pkg::USED_W'(lpsp_pkg::WORD_BITS))

    // A partial word is zero below its valid bits.
    `LPSP_ASSERT_NOW(a_zero_pad, clk, rst_n, res_valid, (res_word << res_bits_used) == '0)

endmodule

bind led_pixel_symbol_packer_unit lpsp_checker u_lpsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_word      (res.word),
    .res_bits_used (res.bits_used),
    .res_last_word (res.last_word)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LED pixel symbol packer: pixels in, packed line words out.
module tb_top;

    // Unused configuration indexes; writes to them must leave the patterns alone.
    localparam logic [lpsp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lpsp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int RANDOM_PIXELS = 410;
    localparam int IDLE_PCT      = 26;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic [lpsp_pkg::WORD_BITS-1:0] word;
        logic [lpsp_pkg::USED_W-1:0]    bits_used;
        logic                           last_word;
    } line_word_t;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        lpsp_pkg::pixel_t                   px;
        logic [lpsp_pkg::CFG_IDX_W-1:0]     reg_idx;
        logic [lpsp_pkg::CFG_DATA_W-1:0]    reg_val;
        int                                 n_typed;
        line_word_t [2:0]                   typed;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lpsp_cfg_if   cfg();
    lpsp_pixel_if pix();
    lpsp_word_if  res();

    led_pixel_symbol_packer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pix   (pix),
        .res   (res)
    );

    // Packer model state and the line words still owed by the block.
    logic [lpsp_pkg::SYMBOL_BITS-1:0] pat_one;
    logic [lpsp_pkg::SYMBOL_BITS-1:0] pat_zero;
    logic [lpsp_pkg::WORD_BITS-1:0]   acc_word;
    int                               acc_fill;
    line_word_t                       fresh_words[$];
    line_word_t                       pending_words[$];
    stim_row_t                        directed_rows[$];

    int  error_count;
    int  words_checked;
    int  pixels_sent;
    int  frames_sent;
    int  settings_used;
    bit  steady_run;

    // Expand one pixel into line symbols and collect every word it completes.
    function automatic void pack_pixel(input lpsp_pkg::pixel_t px);
        logic [lpsp_pkg::DATA_BITS-1:0]   data;
        logic [lpsp_pkg::SYMBOL_BITS-1:0] sym;
        fresh_words.delete();
        data = px.pixel_on ? {px.green, px.red, px.blue} : '0;
        for (int b = lpsp_pkg::DATA_BITS - 1; b >= 0; b--)
        begin
            sym = data[b] ? pat_one : pat_zero;
            for (int s = lpsp_pkg::SYMBOL_BITS - 1; s >= 0; s--)
            begin
                acc_word[lpsp_pkg::WORD_BITS - 1 - acc_fill] = sym[s];
                acc_fill++;
                if (acc_fill == lpsp_pkg::WORD_BITS)
                begin
                    fresh_words.push_back('{acc_word,
                                            lpsp_pkg::USED_W'(lpsp_pkg::WORD_BITS), 1'b0});
                    acc_word = '0;
                    acc_fill = 0;
                end
            end
        end
        // Frame end: flush a partial word, mark the final word, start clean.
        if (px.last_pixel)
        begin
            if (acc_fill > 0)
                fresh_words.push_back('{acc_word, lpsp_pkg::USED_W'(acc_fill), 1'b0});
            if (fresh_words.size() > 0)
                fresh_words[fresh_words.size() - 1].last_word = 1'b1;
            acc_word = '0;
            acc_fill = 0;
        end
    endfunction

    function automatic void add_pixel(input logic [lpsp_pkg::COLOR_BITS-1:0] g, r, b,
                                      input logic on, last);
        stim_row_t row;
        row.kind    = ROW_PIXEL;
        row.px      = '{g, r, b, on, last};
        row.reg_idx = '0;
        row.reg_val = '0;
        row.n_typed = 0;
        row.typed   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [lpsp_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lpsp_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind    = ROW_REG;
        row.px      = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        row.n_typed = 0;
        row.typed   = '0;
        directed_rows.push_back(row);
    endfunction

    // Attach a hand-computed word to the most recent pixel row.
    function automatic void add_typed(input logic [lpsp_pkg::WORD_BITS-1:0] w,
                                      input int used, input logic last);
        stim_row_t row;
        row = directed_rows.pop_back();
        row.typed[row.n_typed] = '{w, lpsp_pkg::USED_W'(used), last};
        row.n_typed++;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [lpsp_pkg::COLOR_BITS-1:0] pick_color();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return lpsp_pkg::COLOR_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one pixel; entered and left at a falling edge.
    task automatic send_pixel(input lpsp_pkg::pixel_t px, input int n_typed,
                              input line_word_t [2:0] typed);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pix.valid <= 1'b0;
            @(negedge clk);
        end
        pix.valid      <= 1'b1;
        pix.green      <= px.green;
        pix.red        <= px.red;
        pix.blue       <= px.blue;
        pix.pixel_on   <= px.pixel_on;
        pix.last_pixel <= px.last_pixel;
        do
            @(posedge clk);
        while (!pix.ready);
        pack_pixel(px);
        if (n_typed > 0)
        begin
            for (int i = 0; i < n_typed; i++)
                pending_words.push_back(typed[i]);
        end
        else
        begin
            foreach (fresh_words[i])
                pending_words.push_back(fresh_words[i]);
        end
        pixels_sent++;
        if (px.last_pixel)
            frames_sent++;
        @(negedge clk);
    endtask

    // Stop feeding pixels and let the block drain before touching registers.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One register write; valid is dropped again before the task returns.
    task automatic write_reg(input logic [lpsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpsp_pkg::CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == lpsp_pkg::REG_SYMBOL_ONE)
            pat_one = val;
        else if (idx == lpsp_pkg::REG_SYMBOL_ZERO)
            pat_zero = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side: random back-pressure outside the steady stretch.
    always @(negedge clk)
    begin
        res.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each accepted word with the oldest outstanding one.
    always @(posedge clk)
    begin
        line_word_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word %h (bits_used %0d, last_word %0b)",
                       res.word, res.bits_used, res.last_word);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (res.word !== want.word)
                begin
                    $error("word: expected %h, got %h", want.word, res.word);
                    error_count++;
                end
                if (res.bits_used !== want.bits_used)
                begin
                    $error("bits_used: expected %0d, got %0d", want.bits_used, res.bits_used);
                    error_count++;
                end
                if (res.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0b, got %0b", want.last_word, res.last_word);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random frames under several pattern settings.
    initial
    begin
        lpsp_pkg::pixel_t px;
        int               phase;
        int               phase_len;
        int               frame_left;
        int               random_sent;

        rst_n          = 1'b0;
        pix.valid      = 1'b0;
        pix.green      = '0;
        pix.red        = '0;
        pix.blue       = '0;
        pix.pixel_on   = 1'b0;
        pix.last_pixel = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = '0;
        cfg.data       = '0;
        res.ready      = 1'b0;
        steady_run     = 1'b0;
        error_count    = 0;
        words_checked  = 0;
        pixels_sent    = 0;
        frames_sent    = 0;
        settings_used  = 1;
        pat_one        = lpsp_pkg::SYMBOL_HIGH_RST;
        pat_zero       = lpsp_pkg::SYMBOL_LOW_RST;
        acc_word       = '0;
        acc_fill       = 0;

        // Reset-value patterns: a dark pixel is "100" repeated, a full one "110".
        add_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
        add_typed(32'h92492492, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h49249249, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h24000000, 8, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        add_typed(32'hDB6DB6DB, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h6DB6DB6D, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'hB6000000, 8, 1'b1);
        add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
        add_typed(32'h92492492, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h49249249, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h24000000, 8, 1'b1);
        // A disabled pixel ignores its colour bytes.
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        add_typed(32'h92492492, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h49249249, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h24000000, 8, 1'b1);
        // Four pixels fill exactly nine words: the last full word closes the frame.
        add_pixel(8'hA5, 8'h5A, 8'h3C, 1'b1, 1'b0);
        add_pixel(8'hC3, 8'h81, 8'h7E, 1'b1, 1'b0);
        add_pixel(8'h12, 8'h34, 8'h56, 1'b0, 1'b0);
        add_pixel(8'h80, 8'h01, 8'hFE, 1'b1, 1'b1);
        // Two-pixel frame: words straddle the pixel boundary.
        add_pixel(8'h0F, 8'hF0, 8'h99, 1'b1, 1'b0);
        add_pixel(8'h66, 8'h01, 8'h80, 1'b1, 1'b1);
        // Solid patterns make the words trivial to read.
        add_reg(lpsp_pkg::REG_SYMBOL_ONE, 3'd7);
        add_reg(lpsp_pkg::REG_SYMBOL_ZERO, 3'd0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        add_typed(32'hFFFFFFFF, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'hFFFFFFFF, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'hFF000000, 8, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        add_typed(32'h00000000, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h00000000, lpsp_pkg::WORD_BITS, 1'b0);
        add_typed(32'h00000000, 8, 1'b1);
        // Writes to unused indexes must not disturb the patterns.
        add_reg(REG_SPARE_2, 3'd5);
        add_reg(REG_SPARE_3, 3'd2);
        add_pixel(8'h0F, 8'hF0, 8'hAA, 1'b1, 1'b1);
        // Inverted extremes.
        add_reg(lpsp_pkg::REG_SYMBOL_ONE, 3'd0);
        add_reg(lpsp_pkg::REG_SYMBOL_ZERO, 3'd7);
        add_pixel(8'h01, 8'h80, 8'h7E, 1'b1, 1'b0);
        add_pixel(8'hFE, 8'h7F, 8'h00, 1'b1, 1'b1);
        // Alternating patterns over a three-pixel frame.
        add_reg(lpsp_pkg::REG_SYMBOL_ONE, 3'd5);
        add_reg(lpsp_pkg::REG_SYMBOL_ZERO, 3'd2);
        add_pixel(8'hC3, 8'h3C, 8'h99, 1'b1, 1'b0);
        add_pixel(8'h55, 8'hAA, 8'h11, 1'b0, 1'b0);
        add_pixel(8'h24, 8'h42, 8'hE7, 1'b1, 1'b1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                if (directed_rows[i].reg_idx == lpsp_pkg::REG_SYMBOL_ONE)
                    settings_used++;
            end
            else
            begin
                send_pixel(directed_rows[i].px, directed_rows[i].n_typed,
                           directed_rows[i].typed);
            end
        end

        // Random frames; each phase starts from an idle block with new patterns.
        random_sent = 0;
        phase       = 0;
        frame_left  = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(lpsp_pkg::REG_SYMBOL_ONE, 3'd7);
                    write_reg(lpsp_pkg::REG_SYMBOL_ZERO, 3'd0);
                end
                1:
                begin
                    write_reg(lpsp_pkg::REG_SYMBOL_ONE, 3'd0);
                    write_reg(lpsp_pkg::REG_SYMBOL_ZERO, 3'd7);
                end
                2:
                begin
                    write_reg(lpsp_pkg::REG_SYMBOL_ONE, lpsp_pkg::SYMBOL_HIGH_RST);
                    write_reg(lpsp_pkg::REG_SYMBOL_ZERO, lpsp_pkg::SYMBOL_LOW_RST);
                end
                default:
                begin
                    write_reg(lpsp_pkg::REG_SYMBOL_ONE,
                              lpsp_pkg::CFG_DATA_W'($urandom_range(0, 7)));
                    write_reg(lpsp_pkg::REG_SYMBOL_ZERO,
                              lpsp_pkg::CFG_DATA_W'($urandom_range(0, 7)));
                    if ($urandom_range(0, 3) == 0)
                        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                                  lpsp_pkg::CFG_DATA_W'($urandom_range(0, 7)));
                end
            endcase
            settings_used++;
            phase_len = $urandom_range(30, 60);
            for (int k = 0; k < phase_len && random_sent < RANDOM_PIXELS; k++)
            begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(0, 4) == 0) ? 4 : $urandom_range(1, 9);
                px.green      = pick_color();
                px.red        = pick_color();
                px.blue       = pick_color();
                px.pixel_on   = ($urandom_range(0, 99) < 85);
                px.last_pixel = (frame_left == 1);
                // Most phases end on a frame boundary; some stop mid-frame.
                if (k == phase_len - 1 && $urandom_range(0, 3) != 0)
                    px.last_pixel = 1'b1;
                frame_left = px.last_pixel ? 0 : frame_left - 1;
                steady_run = (random_sent >= 150 && random_sent < 240);
                send_pixel(px, 0, '0);
                random_sent++;
            end
            steady_run = 1'b0;
            phase++;
        end

        // Drain and allow time for any stray extra words to show up.
        pix.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d pixels in %0d frames across %0d symbol pattern settings.",
                 pixels_sent, frames_sent, settings_used);
        $display("Checked %0d line words; %0d mismatches.", words_checked, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
